### src/ntsa_pkg.sv
// ----------------------------------------------------------------------------
// ntsa_pkg: shared types and constants of the NxN tile source address unit
// Field widths, register indexes, setup states and the structs handed along
// the remainder chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ntsa_pkg;

   // Limits and field widths
   localparam int MAX_DIM    = 4096;
   localparam int MAX_TILES  = 256;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int TILES_W    = 9;
   localparam int INDEX_W    = 24;
   localparam int EXTRA_W    = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam int DIV_STEPS  = DIM_W;
   localparam int CNT_W      = 4;
   localparam int REM_CELLS  = COORD_W;
   localparam int PROD_W     = 2 * DIM_W;

   typedef logic [COORD_W-1:0]    ntsa_coord_type;
   typedef logic [DIM_W-1:0]      ntsa_dim_type;
   typedef logic [TILES_W-1:0]    ntsa_tiles_type;
   typedef logic [EXTRA_W-1:0]    ntsa_extra_type;
   typedef logic [INDEX_W-1:0]    ntsa_index_type;
   typedef logic [CSR_ADDR_W-1:0] ntsa_csr_addr_type;
   typedef logic [CNT_W-1:0]      ntsa_cnt_type;
   typedef logic [PROD_W-1:0]     ntsa_prod_type;

   // Register indexes
   localparam ntsa_csr_addr_type CSR_TILES  = ntsa_csr_addr_type'(0);
   localparam ntsa_csr_addr_type CSR_WIDTH  = ntsa_csr_addr_type'(1);
   localparam ntsa_csr_addr_type CSR_HEIGHT = ntsa_csr_addr_type'(2);

   // Register reset values and clamp bounds
   localparam ntsa_tiles_type TILES_RESET  = ntsa_tiles_type'(2);
   localparam ntsa_dim_type   WIDTH_RESET  = ntsa_dim_type'(640);
   localparam ntsa_dim_type   HEIGHT_RESET = ntsa_dim_type'(480);
   localparam ntsa_tiles_type TILES_MIN    = ntsa_tiles_type'(1);
   localparam ntsa_tiles_type TILES_MAX    = ntsa_tiles_type'(MAX_TILES);
   localparam ntsa_dim_type   DIM_MAX      = ntsa_dim_type'(MAX_DIM);

   // Setup sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIV,
      ST_MUL,
      ST_RUN
   } ntsa_state_type;

   // Tiling geometry derived from the registers
   typedef struct packed {
      ntsa_tiles_type n;
      ntsa_dim_type   w;
      ntsa_dim_type   h;
      ntsa_dim_type   big_r;
      ntsa_dim_type   small_r;
      ntsa_dim_type   split_r;
      ntsa_dim_type   big_c;
      ntsa_dim_type   small_c;
      ntsa_dim_type   split_c;
   } ntsa_geom_type;

   // One axis of a remainder in progress
   typedef struct packed {
      ntsa_dim_type   rem;
      ntsa_coord_type dvd;
      ntsa_dim_type   div;
   } ntsa_axis_type;

   // One request as it travels down the chain
   typedef struct packed {
      ntsa_axis_type row;
      ntsa_axis_type col;
      logic          oor;
   } ntsa_item_type;

endpackage

`default_nettype wire

### src/ntsa_setup.sv
// ----------------------------------------------------------------------------
// ntsa_setup: configuration registers and tiling geometry
// Holds the registers and, after reset or any write, derives tile sizes and
// split points for both axes with a serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ntsa_setup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  ntsa_pkg::ntsa_csr_addr_type   csr_index,
   input  logic [ntsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ntsa_pkg::ntsa_geom_type       geom,
   output logic                          geom_ok
);

   ntsa_pkg::ntsa_tiles_type tiles_ff, tiles_in;
   ntsa_pkg::ntsa_dim_type   width_ff, width_in;
   ntsa_pkg::ntsa_dim_type   height_ff, height_in;
   ntsa_pkg::ntsa_state_type state_ff, state_in;
   ntsa_pkg::ntsa_cnt_type   cnt_ff, cnt_in;

   ntsa_pkg::ntsa_tiles_type n_ff, n_in;
   ntsa_pkg::ntsa_dim_type   w_ff, w_in;
   ntsa_pkg::ntsa_dim_type   h_ff, h_in;
   ntsa_pkg::ntsa_dim_type   dvd_h_ff, dvd_h_in, dvd_w_ff, dvd_w_in;
   ntsa_pkg::ntsa_extra_type rem_h_ff, rem_h_in, rem_w_ff, rem_w_in;
   ntsa_pkg::ntsa_dim_type   quo_h_ff, quo_h_in, quo_w_ff, quo_w_in;
   ntsa_pkg::ntsa_dim_type   big_h_ff, big_h_in, big_w_ff, big_w_in;
   ntsa_pkg::ntsa_dim_type   small_h_ff, small_h_in, small_w_ff, small_w_in;
   ntsa_pkg::ntsa_dim_type   split_h_ff, split_h_in, split_w_ff, split_w_in;

   logic load_en, div_en, mul_en;

   ntsa_pkg::ntsa_tiles_type n_clamp;
   ntsa_pkg::ntsa_dim_type   w_clamp, h_clamp;
   ntsa_pkg::ntsa_tiles_type part_h, part_w;
   logic                     ge_h, ge_w;
   ntsa_pkg::ntsa_dim_type   big_h, big_w;
   logic [ntsa_pkg::EXTRA_W+ntsa_pkg::DIM_W-1:0] prod_h, prod_w;

   // Take register writes
   always_comb begin
      tiles_in  = tiles_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            ntsa_pkg::CSR_TILES:  tiles_in  = csr_wdata[ntsa_pkg::TILES_W-1:0];
            ntsa_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            ntsa_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state: restart the derivation on every write
   always_comb begin
      case (state_ff)
         ntsa_pkg::ST_LOAD: state_in = ntsa_pkg::ST_DIV;
         ntsa_pkg::ST_DIV: begin
            if (cnt_ff == ntsa_pkg::ntsa_cnt_type'(ntsa_pkg::DIV_STEPS - 1)) begin
               state_in = ntsa_pkg::ST_MUL;
            end else begin
               state_in = ntsa_pkg::ST_DIV;
            end
         end
         ntsa_pkg::ST_MUL: state_in = ntsa_pkg::ST_RUN;
         ntsa_pkg::ST_RUN: state_in = ntsa_pkg::ST_RUN;
         default:          state_in = ntsa_pkg::ST_LOAD;
      endcase
      if (csr_we) begin
         state_in = ntsa_pkg::ST_LOAD;
      end
   end

   // State outputs
   always_comb begin
      load_en = 1'b0;
      div_en  = 1'b0;
      mul_en  = 1'b0;
      geom_ok = 1'b0;
      case (state_ff)
         ntsa_pkg::ST_LOAD: load_en = 1'b1;
         ntsa_pkg::ST_DIV:  div_en  = 1'b1;
         ntsa_pkg::ST_MUL:  mul_en  = 1'b1;
         ntsa_pkg::ST_RUN:  geom_ok = 1'b1;
         default: ;
      endcase
   end

   // Clamp the factor to its range and the dimensions to the maximum
   always_comb begin
      if (tiles_ff == '0) begin
         n_clamp = ntsa_pkg::TILES_MIN;
      end else if (tiles_ff > ntsa_pkg::TILES_MAX) begin
         n_clamp = ntsa_pkg::TILES_MAX;
      end else begin
         n_clamp = tiles_ff;
      end
      w_clamp = (width_ff > ntsa_pkg::DIM_MAX) ? ntsa_pkg::DIM_MAX : width_ff;
      h_clamp = (height_ff > ntsa_pkg::DIM_MAX) ? ntsa_pkg::DIM_MAX : height_ff;
   end

   // One restoring step per axis: dimension / n
   always_comb begin
      part_h = {rem_h_ff, dvd_h_ff[ntsa_pkg::DIM_W-1]};
      part_w = {rem_w_ff, dvd_w_ff[ntsa_pkg::DIM_W-1]};
      ge_h   = (part_h >= n_ff);
      ge_w   = (part_w >= n_ff);
   end

   // Tile size, smaller tile size and split point
   always_comb begin
      big_h  = quo_h_ff + ntsa_pkg::ntsa_dim_type'(rem_h_ff != '0);
      big_w  = quo_w_ff + ntsa_pkg::ntsa_dim_type'(rem_w_ff != '0);
      prod_h = rem_h_ff * big_h;
      prod_w = rem_w_ff * big_w;
   end

   // Datapath next values
   always_comb begin
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      dvd_h_in   = dvd_h_ff;
      dvd_w_in   = dvd_w_ff;
      rem_h_in   = rem_h_ff;
      rem_w_in   = rem_w_ff;
      quo_h_in   = quo_h_ff;
      quo_w_in   = quo_w_ff;
      big_h_in   = big_h_ff;
      big_w_in   = big_w_ff;
      small_h_in = small_h_ff;
      small_w_in = small_w_ff;
      split_h_in = split_h_ff;
      split_w_in = split_w_ff;
      if (load_en) begin
         cnt_in   = '0;
         n_in     = n_clamp;
         w_in     = w_clamp;
         h_in     = h_clamp;
         dvd_h_in = h_clamp;
         dvd_w_in = w_clamp;
         rem_h_in = '0;
         rem_w_in = '0;
         quo_h_in = '0;
         quo_w_in = '0;
      end
      if (div_en) begin
         cnt_in   = cnt_ff + ntsa_pkg::ntsa_cnt_type'(1);
         dvd_h_in = {dvd_h_ff[ntsa_pkg::DIM_W-2:0], 1'b0};
         dvd_w_in = {dvd_w_ff[ntsa_pkg::DIM_W-2:0], 1'b0};
         rem_h_in = ge_h ? ntsa_pkg::ntsa_extra_type'(part_h - n_ff)
                         : ntsa_pkg::ntsa_extra_type'(part_h);
         rem_w_in = ge_w ? ntsa_pkg::ntsa_extra_type'(part_w - n_ff)
                         : ntsa_pkg::ntsa_extra_type'(part_w);
         quo_h_in = {quo_h_ff[ntsa_pkg::DIM_W-2:0], ge_h};
         quo_w_in = {quo_w_ff[ntsa_pkg::DIM_W-2:0], ge_w};
      end
      if (mul_en) begin
         big_h_in   = big_h;
         big_w_in   = big_w;
         // an even split has no smaller tiles: every tile keeps the full size
         small_h_in = (rem_h_ff == '0) ? big_h : big_h - ntsa_pkg::ntsa_dim_type'(1);
         small_w_in = (rem_w_ff == '0) ? big_w : big_w - ntsa_pkg::ntsa_dim_type'(1);
         split_h_in = prod_h[ntsa_pkg::DIM_W-1:0];
         split_w_in = prod_w[ntsa_pkg::DIM_W-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_ff  <= ntsa_pkg::TILES_RESET;
         width_ff  <= ntsa_pkg::WIDTH_RESET;
         height_ff <= ntsa_pkg::HEIGHT_RESET;
         state_ff  <= ntsa_pkg::ST_LOAD;
         cnt_ff    <= '0;
      end else begin
         tiles_ff  <= tiles_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Geometry registers
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      dvd_h_ff   <= dvd_h_in;
      dvd_w_ff   <= dvd_w_in;
      rem_h_ff   <= rem_h_in;
      rem_w_ff   <= rem_w_in;
      quo_h_ff   <= quo_h_in;
      quo_w_ff   <= quo_w_in;
      big_h_ff   <= big_h_in;
      big_w_ff   <= big_w_in;
      small_h_ff <= small_h_in;
      small_w_ff <= small_w_in;
      split_h_ff <= split_h_in;
      split_w_ff <= split_w_in;
   end

   assign geom.n       = n_ff;
   assign geom.w       = w_ff;
   assign geom.h       = h_ff;
   assign geom.big_r   = big_h_ff;
   assign geom.small_r = small_h_ff;
   assign geom.split_r = split_h_ff;
   assign geom.big_c   = big_w_ff;
   assign geom.small_c = small_w_ff;
   assign geom.split_c = split_w_ff;

   // Larger tiles never reach past the end of the axis
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ntsa_pkg::ST_RUN) |-> (split_h_ff <= h_ff) && (split_w_ff <= w_ff))
      else $error("split point beyond image dimension");

endmodule

`default_nettype wire

### src/ntsa_cell.sv
// ----------------------------------------------------------------------------
// ntsa_cell: one step of the remainder chain
// Shifts one dividend bit into the partial remainder of each axis and
// subtracts the divisor where it fits, then hands the request on.
// ----------------------------------------------------------------------------
`default_nettype none

module ntsa_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ntsa_pkg::ntsa_item_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output ntsa_pkg::ntsa_item_type out_data,
   input  logic                    out_ready
);

   logic                    valid_ff, valid_in;
   ntsa_pkg::ntsa_item_type data_ff, data_in;
   ntsa_pkg::ntsa_item_type step;

   function automatic ntsa_pkg::ntsa_axis_type rem_step(input ntsa_pkg::ntsa_axis_type a);
      ntsa_pkg::ntsa_axis_type r;
      ntsa_pkg::ntsa_dim_type  part;
      part  = {a.rem[ntsa_pkg::DIM_W-2:0], a.dvd[ntsa_pkg::COORD_W-1]};
      r.div = a.div;
      r.dvd = {a.dvd[ntsa_pkg::COORD_W-2:0], 1'b0};
      r.rem = (part >= a.div) ? part - a.div : part;
      return r;
   endfunction

   // Advance one bit on both axes
   always_comb begin
      step.row = rem_step(in_data.row);
      step.col = rem_step(in_data.col);
      step.oor = in_data.oor;
   end

   // Hold while the next cell is full and stalled
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = (in_valid && in_ready) ? step : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Partial remainder always stays below a non-zero divisor
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.row.rem < data_ff.row.div) && (data_ff.col.rem < data_ff.col.div))
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

### src/ntsa_scale.sv
// ----------------------------------------------------------------------------
// ntsa_scale: scaling of tile offsets into a linear source index
// Multiplies the offsets by the tiling factor, the source row by the width,
// adds the column and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ntsa_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ntsa_pkg::ntsa_item_type in_data,
   output logic                    in_ready,
   input  ntsa_pkg::ntsa_geom_type geom,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ntsa_pkg::ntsa_index_type rsp_src_index,
   output logic                    rsp_out_of_range
);

   // Stage A: source row and column
   logic                   a_valid_ff, a_valid_in;
   ntsa_pkg::ntsa_dim_type a_row_ff, a_row_in, a_col_ff, a_col_in;
   logic                   a_oor_ff, a_oor_in;
   // Stage B: row times width
   logic                    b_valid_ff, b_valid_in;
   ntsa_pkg::ntsa_prod_type b_prod_ff, b_prod_in;
   ntsa_pkg::ntsa_dim_type  b_col_ff, b_col_in;
   logic                    b_oor_ff, b_oor_in;
   // Output register
   logic                     out_valid_ff, out_valid_in;
   ntsa_pkg::ntsa_index_type idx_ff, idx_in;
   logic                     oor_ff, oor_in;

   logic a_ready, b_ready, c_ready;
   logic [ntsa_pkg::TILES_W+ntsa_pkg::COORD_W-1:0] row_prod, col_prod;

   // Ready chain from the output back
   assign c_ready  = !out_valid_ff || rsp_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Scale offsets by the tiling factor
   always_comb begin
      row_prod   = geom.n * in_data.row.rem[ntsa_pkg::COORD_W-1:0];
      col_prod   = geom.n * in_data.col.rem[ntsa_pkg::COORD_W-1:0];
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      a_row_in   = a_row_ff;
      a_col_in   = a_col_ff;
      a_oor_in   = a_oor_ff;
      if (in_valid && a_ready) begin
         a_row_in = row_prod[ntsa_pkg::DIM_W-1:0];
         a_col_in = col_prod[ntsa_pkg::DIM_W-1:0];
         a_oor_in = in_data.oor;
      end
   end

   // Row times width
   always_comb begin
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_prod_in  = b_prod_ff;
      b_col_in   = b_col_ff;
      b_oor_in   = b_oor_ff;
      if (a_valid_ff && b_ready) begin
         b_prod_in = a_row_ff * geom.w;
         b_col_in  = a_col_ff;
         b_oor_in  = a_oor_ff;
      end
   end

   // Add the column, drop to zero outside the image
   always_comb begin
      out_valid_in = c_ready ? b_valid_ff : out_valid_ff;
      idx_in       = idx_ff;
      oor_in       = oor_ff;
      if (b_valid_ff && c_ready) begin
         idx_in = b_oor_ff ? '0 : b_prod_ff[ntsa_pkg::INDEX_W-1:0]
                                  + ntsa_pkg::ntsa_index_type'(b_col_ff);
         oor_in = b_oor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_row_ff  <= a_row_in;
      a_col_ff  <= a_col_in;
      a_oor_ff  <= a_oor_in;
      b_prod_ff <= b_prod_in;
      b_col_ff  <= b_col_in;
      b_oor_ff  <= b_oor_in;
      idx_ff    <= idx_in;
      oor_ff    <= oor_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_src_index    = idx_ff;
   assign rsp_out_of_range = oor_ff;

   // A coordinate outside the image always reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && oor_ff) |-> (idx_ff == '0))
      else $error("out-of-range response with non-zero index");

endmodule

`default_nettype wire

### src/nxn_tile_source_address_unit.sv
// ----------------------------------------------------------------------------
// nxn_tile_source_address_unit: NxN tiling source address generator
// For each output pixel coordinate, returns the linear index of the source
// pixel that the NxN tiling places there, or flags a coordinate outside.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (req_out_row, req_out_col) enter on a valid/ready channel; each
//   gives one response (rsp_src_index, rsp_out_of_range) on the rsp channel,
//   in request order.
//   Throughput is one request per cycle while the receiver keeps rsp_ready high
//   and the geometry is ready. A response passes the tile selection register,
//   twelve cells of the remainder chain (one dividend bit per cell), two
//   multiply stages and the output register.
//   The csr port writes tiling factor (index 0), width (1) and height (2).
//   After reset and after every write, the tile geometry is derived by a
//   serial divider (load, 13 divide steps, one multiply);
//   req_ready stays low during that time.
//   When the receiver stalls, each stage holds its request and req_ready
//   falls once the chain is full; bubbles still close up behind a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module nxn_tile_source_address_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ntsa_pkg::ntsa_coord_type         req_out_row,
   input  ntsa_pkg::ntsa_coord_type         req_out_col,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ntsa_pkg::ntsa_index_type         rsp_src_index,
   output logic                             rsp_out_of_range,
   input  logic                             csr_we,
   input  ntsa_pkg::ntsa_csr_addr_type      csr_index,
   input  logic [ntsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ntsa_pkg::ntsa_geom_type geom;
   logic                    geom_ok;

   logic                    entry_valid_ff, entry_valid_in;
   ntsa_pkg::ntsa_item_type entry_ff, entry_in;
   ntsa_pkg::ntsa_item_type pick;
   logic                    entry_ready, accept;

   logic                    chain_valid [0:ntsa_pkg::REM_CELLS];
   ntsa_pkg::ntsa_item_type chain_data  [0:ntsa_pkg::REM_CELLS];
   logic                    chain_ready [0:ntsa_pkg::REM_CELLS];

   // Choose dividend and divisor on one axis: the larger tiles come first
   function automatic ntsa_pkg::ntsa_axis_type axis_pick(
      input ntsa_pkg::ntsa_coord_type c,
      input ntsa_pkg::ntsa_dim_type   big,
      input ntsa_pkg::ntsa_dim_type   small_size,
      input ntsa_pkg::ntsa_dim_type   split,
      input logic                     oor
   );
      ntsa_pkg::ntsa_axis_type a;
      ntsa_pkg::ntsa_dim_type  c_ext;
      c_ext = ntsa_pkg::ntsa_dim_type'(c);
      a.rem = '0;
      if (c_ext < split) begin
         a.dvd = c;
         a.div = big;
      end else begin
         a.dvd = ntsa_pkg::ntsa_coord_type'(c_ext - split);
         a.div = small_size;
      end
      // zero-size tiles and outside coordinates give offset zero
      if (a.div == '0 || oor) begin
         a.dvd = '0;
         a.div = ntsa_pkg::ntsa_dim_type'(1);
      end
      return a;
   endfunction

   ntsa_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom),
      .geom_ok   (geom_ok)
   );

   // Range check and tile selection
   always_comb begin
      pick.oor = (ntsa_pkg::ntsa_dim_type'(req_out_row) >= geom.h)
              || (ntsa_pkg::ntsa_dim_type'(req_out_col) >= geom.w);
      pick.row = axis_pick(req_out_row, geom.big_r, geom.small_r, geom.split_r, pick.oor);
      pick.col = axis_pick(req_out_col, geom.big_c, geom.small_c, geom.split_c, pick.oor);
   end

   // Take a request while the geometry is ready and the entry stage can move
   assign entry_ready = !entry_valid_ff || chain_ready[0];
   assign req_ready   = geom_ok && entry_ready;
   assign accept      = req_valid && req_ready;

   always_comb begin
      entry_valid_in = entry_ready ? accept : entry_valid_ff;
      entry_in       = accept ? pick : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_data[0]  = entry_ff;

   // Remainder chain: one dividend bit per cell
   for (genvar k = 0; k < ntsa_pkg::REM_CELLS; k++) begin : g_cell
      ntsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_data   (chain_data[k]),
         .in_ready  (chain_ready[k]),
         .out_valid (chain_valid[k+1]),
         .out_data  (chain_data[k+1]),
         .out_ready (chain_ready[k+1])
      );
   end

   ntsa_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (chain_valid[ntsa_pkg::REM_CELLS]),
      .in_data          (chain_data[ntsa_pkg::REM_CELLS]),
      .in_ready         (chain_ready[ntsa_pkg::REM_CELLS]),
      .geom             (geom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_src_index    (rsp_src_index),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // A register write always closes the request port while geometry rebuilds
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request taken while geometry is being rebuilt");

   // Nothing enters the entry stage without a taken request
   assert property (@(posedge clock) disable iff (reset)
      (!entry_valid_ff && !accept) |=> !entry_valid_ff)
      else $error("entry stage filled without a request");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the NxN tile source address unit
// Drives pixel coordinates through the request channel under several tiling
// and image settings, predicts each source index in a scoreboard and checks
// the responses in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

// Expected response for one request
typedef struct {
   ntsa_pkg::ntsa_coord_type row;
   ntsa_pkg::ntsa_coord_type col;
   ntsa_pkg::ntsa_index_type src_index;
   logic                     outside;
} source_address_type;

class tile_address_scoreboard;
   ntsa_pkg::ntsa_tiles_type tiles_reg;
   ntsa_pkg::ntsa_dim_type   width_reg;
   ntsa_pkg::ntsa_dim_type   height_reg;
   source_address_type       pending_addresses[$];
   int                       errors;
   int                       responses_checked;
   int                       outside_count;

   function new();
      tiles_reg         = ntsa_pkg::TILES_RESET;
      width_reg         = ntsa_pkg::WIDTH_RESET;
      height_reg        = ntsa_pkg::HEIGHT_RESET;
      errors            = 0;
      responses_checked = 0;
      outside_count     = 0;
   endfunction

   // Mirror a register write; unused indexes leave the settings alone
   function void set_register(ntsa_pkg::ntsa_csr_addr_type idx,
                              logic [ntsa_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         ntsa_pkg::CSR_TILES: begin
            tiles_reg = value[ntsa_pkg::TILES_W-1:0];
         end
         ntsa_pkg::CSR_WIDTH: begin
            width_reg = value;
         end
         ntsa_pkg::CSR_HEIGHT: begin
            height_reg = value;
         end
         default: begin
         end
      endcase
   endfunction

   // Offset of a coordinate within its tile along one axis
   function longint unsigned tile_offset(longint unsigned c, longint unsigned dim,
                                         longint unsigned n);
      longint unsigned base;
      longint unsigned extra;
      longint unsigned big;
      longint unsigned split;
      base  = dim / n;
      extra = dim % n;
      big   = base + ((extra != 0) ? 1 : 0);
      if (big == 0) return 0;
      if (extra == 0) return c % big;
      split = extra * big;
      if (c < split) return c % big;
      if (big <= 1) return 0;
      return (c - split) % (big - 1);
   endfunction

   // Work out the source address that the current tiling gives a coordinate
   function source_address_type source_address_of(ntsa_pkg::ntsa_coord_type row,
                                                  ntsa_pkg::ntsa_coord_type col);
      source_address_type addr;
      longint unsigned n;
      longint unsigned w;
      longint unsigned h;
      longint unsigned src_row;
      longint unsigned src_col;
      longint unsigned linear;
      n = tiles_reg;
      if (n < ntsa_pkg::TILES_MIN) n = ntsa_pkg::TILES_MIN;
      if (n > ntsa_pkg::MAX_TILES) n = ntsa_pkg::MAX_TILES;
      w = width_reg;
      if (w > ntsa_pkg::MAX_DIM) w = ntsa_pkg::MAX_DIM;
      h = height_reg;
      if (h > ntsa_pkg::MAX_DIM) h = ntsa_pkg::MAX_DIM;
      addr.row = row;
      addr.col = col;
      if (row >= h || col >= w) begin
         addr.src_index = '0;
         addr.outside   = 1'b1;
      end else begin
         src_row        = n * tile_offset(row, h, n);
         src_col        = n * tile_offset(col, w, n);
         linear         = src_row * w + src_col;
         addr.src_index = linear[ntsa_pkg::INDEX_W-1:0];
         addr.outside   = 1'b0;
      end
      return addr;
   endfunction

   function void note_request(ntsa_pkg::ntsa_coord_type row,
                              ntsa_pkg::ntsa_coord_type col);
      pending_addresses.push_back(source_address_of(row, col));
   endfunction

   // Compare a response with the oldest expectation
   function void check_response(ntsa_pkg::ntsa_index_type src_index, logic outside);
      source_address_type exp_addr;
      if (pending_addresses.size() == 0) begin
         $display("%0t: response with nothing expected: src_index %0d out_of_range %0b",
                  $time, src_index, outside);
         errors++;
         return;
      end
      exp_addr = pending_addresses.pop_front();
      responses_checked++;
      if (exp_addr.outside) outside_count++;
      if (src_index !== exp_addr.src_index) begin
         $display("%0t: src_index mismatch at row %0d col %0d: expected %0d, got %0d",
                  $time, exp_addr.row, exp_addr.col, exp_addr.src_index, src_index);
         errors++;
      end
      if (outside !== exp_addr.outside) begin
         $display("%0t: out_of_range mismatch at row %0d col %0d: expected %0b, got %0b",
                  $time, exp_addr.row, exp_addr.col, exp_addr.outside, outside);
         errors++;
      end
   endfunction

   function int pending();
      return pending_addresses.size();
   endfunction
endclass

module tb_top;

   localparam ntsa_pkg::ntsa_csr_addr_type CSR_UNUSED = ntsa_pkg::ntsa_csr_addr_type'(3);
   localparam int RANDOM_PER_SETTING = 100;
   localparam int RANDOM_SETTINGS    = 10;
   localparam int HOLD_AFTER         = 250;
   localparam int HOLD_CYCLES        = 150;
   localparam int DRAIN_CYCLES       = 40;
   localparam int CYCLE_LIMIT        = 800000;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   ntsa_pkg::ntsa_coord_type        req_out_row;
   ntsa_pkg::ntsa_coord_type        req_out_col;
   logic                            rsp_valid;
   logic                            rsp_ready;
   ntsa_pkg::ntsa_index_type        rsp_src_index;
   logic                            rsp_out_of_range;
   logic                            csr_we;
   ntsa_pkg::ntsa_csr_addr_type     csr_index;
   logic [ntsa_pkg::CSR_DATA_W-1:0] csr_wdata;

   tile_address_scoreboard sb = new();
   bit steady_flow;
   int settings_used;
   int cycles;

   nxn_tile_source_address_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_out_row      (req_out_row),
      .req_out_col      (req_out_col),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_src_index    (rsp_src_index),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // Mostly no gap, some short ones and a few long ones
   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receive responses, with random stalls and one long hold-off
   initial begin
      int stall_left;
      int hold_left;
      int received;
      bit hold_done;
      stall_left = 0;
      hold_left  = 0;
      received   = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_src_index, rsp_out_of_range);
            received++;
         end
         if (!hold_done && received >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Offer one request and hold it until taken
   task automatic send_request(ntsa_pkg::ntsa_coord_type row,
                               ntsa_pkg::ntsa_coord_type col);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_out_row <= row;
      req_out_col <= col;
      do @(posedge clock); while (!req_ready);
      sb.note_request(row, col);
   endtask

   task automatic write_register(ntsa_pkg::ntsa_csr_addr_type idx,
                                 logic [ntsa_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic apply_setting(logic [ntsa_pkg::CSR_DATA_W-1:0] tiles,
                                logic [ntsa_pkg::CSR_DATA_W-1:0] width,
                                logic [ntsa_pkg::CSR_DATA_W-1:0] height);
      write_register(ntsa_pkg::CSR_TILES, tiles);
      write_register(ntsa_pkg::CSR_WIDTH, width);
      write_register(ntsa_pkg::CSR_HEIGHT, height);
      settings_used++;
      steady_flow = (settings_used % 4 == 3);
   endtask

   // Drop valid and wait for every response before touching the registers
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly coordinates inside the image, some on the edge, some anywhere
   task automatic random_requests(int count);
      int h;
      int w;
      int r;
      ntsa_pkg::ntsa_coord_type row;
      ntsa_pkg::ntsa_coord_type col;
      h = (sb.height_reg > ntsa_pkg::MAX_DIM) ? ntsa_pkg::MAX_DIM : int'(sb.height_reg);
      w = (sb.width_reg > ntsa_pkg::MAX_DIM) ? ntsa_pkg::MAX_DIM : int'(sb.width_reg);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 80 && h > 0 && w > 0) begin
            row = ntsa_pkg::ntsa_coord_type'($urandom_range(0, h - 1));
            col = ntsa_pkg::ntsa_coord_type'($urandom_range(0, w - 1));
         end else if (r < 90) begin
            row = ntsa_pkg::ntsa_coord_type'(h - 1 + $urandom_range(0, 1));
            col = ntsa_pkg::ntsa_coord_type'(w - 1 + $urandom_range(0, 1));
         end else begin
            row = ntsa_pkg::ntsa_coord_type'($urandom);
            col = ntsa_pkg::ntsa_coord_type'($urandom);
         end
         send_request(row, col);
      end
   endtask

   initial begin
      logic [ntsa_pkg::CSR_DATA_W-1:0] tiles;
      logic [ntsa_pkg::CSR_DATA_W-1:0] width;
      logic [ntsa_pkg::CSR_DATA_W-1:0] height;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_out_row   = '0;
      req_out_col   = '0;
      csr_we        = 1'b0;
      csr_index     = ntsa_pkg::CSR_TILES;
      csr_wdata     = '0;
      steady_flow   = 1'b0;
      settings_used = 1;
      cycles        = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: corners, the last pixel and just outside
      send_request(12'd0, 12'd0);
      send_request(12'd479, 12'd639);
      send_request(12'd1, 12'd1);
      send_request(12'd480, 12'd0);
      send_request(12'd0, 12'd640);
      send_request(12'd4095, 12'd4095);
      send_request(12'd240, 12'd320);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Tiling factor zero acts as identity
      apply_setting(13'd0, 13'd100, 13'd50);
      send_request(12'd0, 12'd0);
      send_request(12'd49, 12'd99);
      send_request(12'd50, 12'd99);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Factor and dimensions beyond their limits saturate
      apply_setting(13'd511, 13'd8191, 13'd8191);
      send_request(12'd0, 12'd0);
      send_request(12'd4095, 12'd4095);
      send_request(12'd4095, 12'd0);
      send_request(12'd2048, 12'd2047);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Empty image: everything lies outside
      apply_setting(13'd256, 13'd0, 13'd0);
      send_request(12'd0, 12'd0);
      send_request(12'd5, 12'd5);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // More tiles than pixels on both axes; a write to an unused index must not matter
      apply_setting(13'd300, 13'd100, 13'd37);
      write_register(CSR_UNUSED, 13'h1FFF);
      send_request(12'd36, 12'd99);
      send_request(12'd10, 12'd20);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Upper data bits ignored for the factor; uneven remainders
      apply_setting(13'h1E03, 13'd10, 13'd7);
      send_request(12'd3, 12'd3);
      send_request(12'd4, 12'd4);
      send_request(12'd6, 12'd9);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Factor dividing the dimensions evenly, full width
      apply_setting(13'd4, 13'd4096, 13'd8);
      send_request(12'd7, 12'd4095);
      send_request(12'd0, 12'd1023);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Factor one at full size
      apply_setting(13'd1, 13'd4096, 13'd4096);
      random_requests(RANDOM_PER_SETTING);
      drain();

      // Random settings, some with tiny images
      repeat (RANDOM_SETTINGS) begin
         tiles = ntsa_pkg::CSR_DATA_W'($urandom_range(2, ntsa_pkg::MAX_TILES));
         if ($urandom_range(0, 3) == 0) begin
            width  = ntsa_pkg::CSR_DATA_W'($urandom_range(1, 64));
            height = ntsa_pkg::CSR_DATA_W'($urandom_range(1, 64));
         end else begin
            width  = ntsa_pkg::CSR_DATA_W'($urandom_range(1, ntsa_pkg::MAX_DIM));
            height = ntsa_pkg::CSR_DATA_W'($urandom_range(1, ntsa_pkg::MAX_DIM));
         end
         apply_setting(tiles, width, height);
         random_requests(RANDOM_PER_SETTING);
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, sb.pending());
         sb.errors++;
      end
      $display("Checked %0d responses (%0d outside the image) over %0d register settings,",
               sb.responses_checked, sb.outside_count, settings_used);
      $display("with random gaps on both sides and one %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
src/ntsa_pkg.sv
src/ntsa_setup.sv
src/ntsa_cell.sv
src/ntsa_scale.sv
src/nxn_tile_source_address_unit.sv
test/tb_top.sv
